FILE: src/apx_pkg.sv
// ----------------------------------------------------------------------------
// apx_pkg: shared types and constants of the atan2 approximation unit
// fixed-point formats, polynomial coefficients and the rounding multiply
// ----------------------------------------------------------------------------
`default_nettype none
package apx_pkg;

  localparam int DefInputBits     = 16;
  localparam int DefAngleFracBits = 12;

  // fraction bits of the internal format and quotient width
  localparam int QF = 24;
  localparam int QW = QF + 1;
  localparam int QB = 28;

  typedef logic signed [QB-1:0] q_t;

  localparam q_t Q_ONE  = 28'sd16777216;
  localparam q_t Q_HALF = 28'sd8388608;
  localparam q_t C_0015 = 28'sd251658;
  localparam q_t C_1031 = 28'sd17297310;
  localparam q_t C_0261 = 28'sd4378853;
  localparam q_t C_0333 = 28'sd5586813;
  localparam q_t C_0200 = 28'sd3355443;
  localparam q_t C_0143 = 28'sd2399142;
  localparam q_t C_PI   = 28'sd52707179;
  localparam q_t C_PI2  = 28'sd26353589;

  // per-transaction flags carried along the divider row
  typedef struct packed {
    logic neg;
    logic swap;
    logic pos;
    logic num_pos;
    logic num_neg;
    logic den_neg;
    logic den_zero;
  } sb_t;

  // product rounded to nearest, halves away from zero, symmetric in sign
  function automatic q_t mulq(q_t a, q_t b);
    logic [QB-1:0]   ma;
    logic [QB-1:0]   mb;
    logic [2*QB-1:0] p;
    logic [2*QB-1:0] r;
    q_t              m;
    ma = a[QB-1] ? QB'(-a) : QB'(a);
    mb = b[QB-1] ? QB'(-b) : QB'(b);
    p  = {{QB{1'b0}}, ma} * {{QB{1'b0}}, mb};
    r  = (p + ((2*QB)'(1) << (QF - 1))) >> QF;
    m  = q_t'(r[QB-1:0]);
    return (a[QB-1] != b[QB-1]) ? -m : m;
  endfunction

endpackage
`default_nettype wire

FILE: src/apx_div_cell.sv
// ----------------------------------------------------------------------------
// apx_div_cell: one restoring division step
// resolves one quotient bit and hands remainder and flags to the next cell
// ----------------------------------------------------------------------------
`default_nettype none
module apx_div_cell
  import apx_pkg::*;
#(
  parameter int InputBits = DefInputBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [InputBits-1:0] rem_i,
  input  wire logic [InputBits-1:0] div_i,
  input  wire logic                 bit_i,
  input  wire logic [QW-1:0]        quo_i,
  input  wire sb_t                  sb_i,
  output logic                      valid_o,
  output logic [InputBits-1:0]      rem_o,
  output logic [InputBits-1:0]      div_o,
  output logic [QW-1:0]             quo_o,
  output sb_t                       sb_o
);

  logic                 valid_q;
  logic [InputBits-1:0] rem_q, rem_d, div_q;
  logic [QW-1:0]        quo_q, quo_d;
  sb_t                  sb_q;
  logic [InputBits:0]   trial;
  logic [InputBits:0]   diff;

  always_comb begin
    trial = {rem_i, bit_i};
    diff  = trial - {1'b0, div_i};
    if (trial >= {1'b0, div_i}) begin
      rem_d = diff[InputBits-1:0];
      quo_d = {quo_i[QW-2:0], 1'b1};
    end else begin
      rem_d = trial[InputBits-1:0];
      quo_d = {quo_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      div_q <= div_i;
      quo_q <= quo_d;
      sb_q  <= sb_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign quo_o   = quo_q;
  assign sb_o    = sb_q;

endmodule
`default_nettype wire

FILE: src/apx_poly.sv
// ----------------------------------------------------------------------------
// apx_poly: polynomial arctangent pipeline
// core pieces, reflection, quadrant fix and rounding to the output format
// ----------------------------------------------------------------------------
`default_nettype none
module apx_poly
  import apx_pkg::*;
#(
  parameter int AngleFracBits = DefAngleFracBits
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [QW-1:0]              quo_i,
  input  wire sb_t                        sb_i,
  output logic                            valid_o,
  output logic signed [AngleFracBits+2:0] angle_o
);

  localparam int AW = AngleFracBits + 3;
  localparam int SH = QF - AngleFracBits;

  logic [5:0] vld_q;
  sb_t        sb1_q, sb2_q, sb3_q, sb4_q, sb5_q;
  q_t         x1_q, x2_q, x3_q, x4_q;
  q_t         t1_q, t2_q, t3_q;
  q_t         ma1_q;
  q_t         big2_q, big3_q, big4_q;
  logic       large1_q, large2_q, large3_q, large4_q;
  q_t         p2_q, p3_q, p4_q;
  q_t         c5_q;
  q_t         x0;
  q_t         big_d;
  q_t         a;
  logic [QB:0] mag;
  logic [QB:0] rnd;
  logic [AW-1:0] r;
  logic signed [AW-1:0] angle_d;
  logic signed [AW-1:0] angle_q;

  assign x0 = sb_i.neg ? -q_t'({{(QB-QW){1'b0}}, quo_i})
                       :  q_t'({{(QB-QW){1'b0}}, quo_i});

  always_comb begin
    if (!x1_q[QB-1]) begin
      big_d = C_0015 + mulq(x1_q, C_1031 - ma1_q);
    end else begin
      big_d = -C_0015 + mulq(x1_q, C_1031 + ma1_q);
    end
  end

  always_comb begin
    if (sb5_q.swap) begin
      a = sb5_q.pos ? (C_PI2 - c5_q) : (-C_PI2 - c5_q);
    end else begin
      a = c5_q;
    end
    if (sb5_q.den_neg && sb5_q.num_pos) begin
      a = a + C_PI;
    end else if (sb5_q.den_neg && sb5_q.num_neg) begin
      a = a - C_PI;
    end
    if (sb5_q.den_zero) begin
      a = sb5_q.num_pos ? C_PI2 : (sb5_q.num_neg ? -C_PI2 : '0);
    end
    mag = a[QB-1] ? (QB+1)'(-a) : (QB+1)'(a);
    rnd = (mag + ((QB+1)'(1) << (SH - 1))) >> SH;
    r   = rnd[AW-1:0];
    angle_d = a[QB-1] ? -$signed(r) : $signed(r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: square and large-branch coefficient
      x1_q     <= x0;
      sb1_q    <= sb_i;
      t1_q     <= mulq(x0, x0);
      ma1_q    <= mulq(x0, C_0261);
      large1_q <= (x0 >= Q_HALF) || (x0 <= -Q_HALF);
      // stage 2
      x2_q     <= x1_q;
      sb2_q    <= sb1_q;
      t2_q     <= t1_q;
      large2_q <= large1_q;
      big2_q   <= big_d;
      p2_q     <= C_0200 + mulq(t1_q, -C_0143);
      // stage 3
      x3_q     <= x2_q;
      sb3_q    <= sb2_q;
      t3_q     <= t2_q;
      large3_q <= large2_q;
      big3_q   <= big2_q;
      p3_q     <= -C_0333 + mulq(t2_q, p2_q);
      // stage 4
      x4_q     <= x3_q;
      sb4_q    <= sb3_q;
      large4_q <= large3_q;
      big4_q   <= big3_q;
      p4_q     <= Q_ONE + mulq(t3_q, p3_q);
      // stage 5
      sb5_q    <= sb4_q;
      c5_q     <= large4_q ? big4_q : mulq(x4_q, p4_q);
      // output register
      angle_q  <= angle_d;
    end
  end

  assign valid_o = vld_q[5];
  assign angle_o = angle_q;

endmodule
`default_nettype wire

FILE: src/atan2_poly_approx_unit.sv
// ----------------------------------------------------------------------------
// atan2_poly_approx_unit: four-quadrant arctangent by piecewise polynomial
// pipelined fixed-point divider row feeding a polynomial pipeline
// ----------------------------------------------------------------------------
// One transaction of numerator and denominator is taken every cycle while
// s_axis_tready_o is high and gives one angle in radians with AngleFracBits
// fraction bits. Each passes through the 25 divider cells (QW), the five
// polynomial stages and the output register. The whole pipeline advances
// whenever the output register is empty or being taken, so s_axis_tready_o
// drops only while a result waits with m_axis_tready_i low.
`default_nettype none
module atan2_poly_approx_unit
  import apx_pkg::*;
#(
  parameter int InputBits     = DefInputBits,
  parameter int AngleFracBits = DefAngleFracBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // numerator, denominator
  input  wire logic [((2*InputBits+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // angle
  output logic [((AngleFracBits+10)/8)*8-1:0] m_axis_tdata_o
);

  localparam int AW = AngleFracBits + 3;
  localparam int OW = ((AngleFracBits + 10) / 8) * 8;

  logic                        en;
  logic signed [InputBits-1:0] num, den;
  logic [InputBits-1:0]        num_mag, den_mag, dvd, dvs;
  logic [InputBits+2:0]        num5, den7;
  sb_t                         sb_in;

  logic                 vld  [0:QW];
  logic [InputBits-1:0] rem  [0:QW];
  logic [InputBits-1:0] dv   [0:QW];
  logic [QW-1:0]        quo  [0:QW];
  sb_t                  sb   [0:QW];

  logic                 out_valid;
  logic signed [AW-1:0] angle;

  assign en              = !out_valid || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_comb begin
    num     = $signed(s_axis_tdata_i[InputBits-1:0]);
    den     = $signed(s_axis_tdata_i[2*InputBits-1:InputBits]);
    num_mag = num[InputBits-1] ? InputBits'(-num) : InputBits'(num);
    den_mag = den[InputBits-1] ? InputBits'(-den) : InputBits'(den);
    num5    = ((InputBits+3)'(num_mag) << 2) + (InputBits+3)'(num_mag);
    den7    = ((InputBits+3)'(den_mag) << 3) - (InputBits+3)'(den_mag);
    sb_in.swap     = num5 > den7;
    sb_in.pos      = num[InputBits-1] == den[InputBits-1];
    sb_in.neg      = num[InputBits-1] != den[InputBits-1];
    sb_in.num_pos  = !num[InputBits-1] && (num != '0);
    sb_in.num_neg  = num[InputBits-1];
    sb_in.den_neg  = den[InputBits-1];
    sb_in.den_zero = den == '0;
    dvd = sb_in.swap ? den_mag : num_mag;
    dvs = sb_in.swap ? num_mag : den_mag;
  end

  assign vld[0] = s_axis_tvalid_i;
  assign rem[0] = dvd >> 1;
  assign dv[0]  = dvs;
  assign quo[0] = '0;
  assign sb[0]  = sb_in;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    apx_div_cell #(
      .InputBits(InputBits)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(vld[k]),
      .rem_i  (rem[k]),
      .div_i  (dv[k]),
      .bit_i  ((k == 0) ? dvd[0] : 1'b0),
      .quo_i  (quo[k]),
      .sb_i   (sb[k]),
      .valid_o(vld[k+1]),
      .rem_o  (rem[k+1]),
      .div_o  (dv[k+1]),
      .quo_o  (quo[k+1]),
      .sb_o   (sb[k+1])
    );
  end

  apx_poly #(
    .AngleFracBits(AngleFracBits)
  ) u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vld[QW]),
    .quo_i  (quo[QW]),
    .sb_i   (sb[QW]),
    .valid_o(out_valid),
    .angle_o(angle)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = OW'(unsigned'(angle));

endmodule
`default_nettype wire

FILE: src/apx_checker.sv
// ----------------------------------------------------------------------------
// apx_checker: port-level checks of the atan2 approximation unit
// attached to the top level by a bind statement
// ----------------------------------------------------------------------------
`default_nettype none
module apx_checker
  import apx_pkg::*;
#(
  parameter int InputBits     = DefInputBits,
  parameter int AngleFracBits = DefAngleFracBits
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic [((2*InputBits+7)/8)*8-1:0] s_axis_tdata_i,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [((AngleFracBits+10)/8)*8-1:0] m_axis_tdata_o
);

  localparam int AW = AngleFracBits + 3;
  localparam int OW = ((AngleFracBits + 10) / 8) * 8;
  localparam logic signed [AW-1:0] Lim = AW'(13 <<< (AngleFracBits - 2));

  logic signed [AW-1:0] ang;
  assign ang = $signed(m_axis_tdata_o[AW-1:0]);

  // a waiting result holds its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // the pipeline advances whenever the output can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stall");

  // angle stays within a little more than pi
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (ang <= Lim) && (ang >= -Lim))
    else $error("angle out of range");

  // padding above the angle is zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o >> AW) == OW'(0))
    else $error("nonzero padding bits");

endmodule

bind atan2_poly_approx_unit apx_checker #(
  .InputBits    (InputBits),
  .AngleFracBits(AngleFracBits)
) u_apx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the atan2 approximation unit
// drives numerator/denominator transactions with random gaps and back
// pressure, predicts each angle in fixed point and checks results in order
// ----------------------------------------------------------------------------
`default_nettype none

class angle_scoreboard;
  logic [14:0] pending_angles[$];
  int          errors;

  function new();
    errors = 0;
  endfunction

  static function longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  static function longint rmul(longint a, longint b);
    longint r;
    r = (mag(a) * mag(b) + (64'sd1 <<< 23)) >>> 24;
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  static function longint qdiv(longint a, longint b);
    longint q;
    q = (mag(a) <<< 24) / mag(b);
    return ((a < 0) != (b < 0)) ? -q : q;
  endfunction

  static function longint poly_atan(longint x);
    longint t, p;
    if (x >= 64'sd8388608) return 251658 + rmul(x, 17297310 - rmul(x, 4378853));
    if (x <= -64'sd8388608) return -251658 + rmul(x, 17297310 + rmul(x, 4378853));
    t = rmul(x, x);
    p = 3355443 + rmul(t, -2399142);
    p = -5586813 + rmul(t, p);
    p = 16777216 + rmul(t, p);
    return rmul(x, p);
  endfunction

  static function logic [14:0] atan2_q12(logic signed [15:0] yn, logic signed [15:0] xd);
    longint n, d, a, c, r;
    n = yn;
    d = xd;
    if (d == 0) begin
      a = n > 0 ? 26353589 : (n < 0 ? -26353589 : 0);
    end else begin
      if (5 * mag(n) > 7 * mag(d)) begin
        c = poly_atan(qdiv(d, n));
        a = ((n < 0) == (d < 0)) ? 26353589 - c : -26353589 - c;
      end else begin
        a = poly_atan(qdiv(n, d));
      end
      if (d < 0 && n > 0) a += 52707179;
      else if (d < 0 && n < 0) a -= 52707179;
    end
    r = (mag(a) + 2048) >>> 12;
    if (a < 0) r = -r;
    return r[14:0];
  endfunction

  function void note_input(logic signed [15:0] yn, logic signed [15:0] xd);
    pending_angles.push_back(atan2_q12(yn, xd));
  endfunction

  function void check_angle(logic [14:0] got);
    logic [14:0] want;
    if (pending_angles.size() == 0) begin
      $display("%0t: unexpected angle %0d", $time, $signed(got));
      errors++;
    end else begin
      want = pending_angles.pop_front();
      if (want !== got) begin
        $display("%0t: angle expected %0d actual %0d", $time, $signed(want), $signed(got));
        errors++;
      end
    end
  endfunction
endclass

module tb_top;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // numerator, denominator
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // angle
  logic [15:0] m_axis_tdata_o;

  angle_scoreboard sb = new();
  bit   calm = 1'b0;
  bit   hold_sink = 1'b0;
  int   idle_cycles = 0;
  logic signed [15:0] corner_vals[8] = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0,
                                         16'sd1, 16'sd5, 16'sd7, 16'sh7fff};

  atan2_poly_approx_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o)
      sb.note_input(s_axis_tdata_i[15:0], s_axis_tdata_i[31:16]);
    if (m_axis_tvalid_o && m_axis_tready_i)
      sb.check_angle(m_axis_tdata_o[14:0]);
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : sink
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_axis_tready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_sink = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 13);
        m_axis_tready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_pair(logic [15:0] yn, logic [15:0] xd);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 13);
      s_axis_tvalid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {xd, yn};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return corner_vals[$urandom_range(0, 7)];
      1: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stim
    logic [15:0] a;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 3; j++)
        send_pair(corner_vals[i], corner_vals[(i * 3 + j * 5) % 8]);
    send_pair(16'sd0, -16'sd9);
    hold_sink = 1'b1;
    for (int k = 0; k < 450; k++) begin
      if (k > 380) calm = 1'b1;
      if (k % 7 == 0) begin
        a = 16'($urandom_range(1, 4681));
        send_pair(16'(7 * a), 16'(5 * a * (k[3] ? -1 : 1)));
      end else begin
        send_pair(rand_operand(), rand_operand());
      end
    end
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_angles.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

`default_nettype wire
